@@ rtl/core/xts_pkg.sv @@
// xts_pkg: shared types, character codes and token kinds of the XML token scanner.
// No dependencies; imported by every module under rtl/core.
package xts_pkg;

    localparam int XTS_OFFSET_BITS = 32;  // default width of byte offsets
    localparam int XTS_QUEUE_DEPTH = 4;   // result queue entries (power of two)

    // Token kinds
    localparam logic [3:0] KIND_END       = 4'd0;
    localparam logic [3:0] KIND_OPEN      = 4'd1;
    localparam logic [3:0] KIND_CLOSE     = 4'd2;
    localparam logic [3:0] KIND_SELFCLOSE = 4'd3;
    localparam logic [3:0] KIND_TEXT      = 4'd4;
    localparam logic [3:0] KIND_COMMENT   = 4'd5;
    localparam logic [3:0] KIND_CDATA     = 4'd6;
    localparam logic [3:0] KIND_DECL      = 4'd7;
    localparam logic [3:0] KIND_ERROR     = 4'd8;

    // Character codes
    localparam logic [7:0] CH_LT    = 8'h3C;  // <
    localparam logic [7:0] CH_GT    = 8'h3E;  // >
    localparam logic [7:0] CH_QUEST = 8'h3F;  // ?
    localparam logic [7:0] CH_SLASH = 8'h2F;  // /
    localparam logic [7:0] CH_BANG  = 8'h21;  // !
    localparam logic [7:0] CH_DASH  = 8'h2D;  // -
    localparam logic [7:0] CH_LBRK  = 8'h5B;  // [
    localparam logic [7:0] CH_RBRK  = 8'h5D;  // ]
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_item;
        logic       end_only;
    } byte_item_t;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [31:0] token_offset;
        logic [31:0] value_offset;
        logic [31:0] value_length;
        logic        run_last;
    } token_item_t;

    // Up to two results of one accepted byte item; r1 only with r0.
    typedef struct packed {
        logic        r0_valid;
        logic        r1_valid;
        token_item_t r0;
        token_item_t r1;
    } res_pair_t;

    // "![CDATA[" prefix, one character per index
    function automatic logic [7:0] cdata_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = CH_BANG;
            3'd1:    ch = CH_LBRK;
            3'd2:    ch = 8'h43;  // C
            3'd3:    ch = 8'h44;  // D
            3'd4:    ch = 8'h41;  // A
            3'd5:    ch = 8'h54;  // T
            3'd6:    ch = 8'h41;  // A
            default: ch = CH_LBRK;
        endcase
        return ch;
    endfunction

endpackage

@@ rtl/core/xts_parse.sv @@
// xts_parse: scanner state machine and offset counters, one byte item per step.
// Depends on xts_pkg; feeds up to two results per step to xts_result_queue.
module xts_parse
    import xts_pkg::*;
#(
    parameter int OFFSET_BITS = XTS_OFFSET_BITS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  byte_item_t item,
    output res_pair_t  res
);

    typedef logic [OFFSET_BITS-1:0] off_t;

    typedef enum logic [3:0] {
        M_SKIP, M_TEXT, M_LT, M_BANG, M_BANG_DASH, M_CDATA_PFX, M_COMMENT, M_CDATA,
        M_DECL_NAME, M_DECL_BODY, M_CLOSE_NAME, M_CLOSE_BODY, M_OPEN_NAME, M_OPEN_BODY
    } mode_t;

    localparam off_t POS_MAX = '1;
    localparam off_t TWO     = off_t'(2);

    function automatic off_t inc_pos(input off_t x);
        return (x == POS_MAX) ? x : x + off_t'(1);
    endfunction

    function automatic off_t sub0(input off_t a, input off_t b);
        return (a > b) ? a - b : '0;
    endfunction

    function automatic logic [31:0] to32(input off_t x);
        logic [63:0] w;
        w = 64'(x);
        return w[31:0];
    endfunction

    function automatic token_item_t mk(input logic [3:0] kind, input off_t tok,
                                       input off_t voff, input off_t vlen);
        token_item_t t;
        t.token_kind   = kind;
        t.token_offset = to32(tok);
        t.value_offset = to32(voff);
        t.value_length = to32(vlen);
        t.run_last     = 1'b0;
        return t;
    endfunction

    mode_t       mode_reg, mode_next, mode_mid;
    off_t        pos_reg, pos_next, pos_mid;
    off_t        tok_reg, tok_next, tok_mid;
    off_t        fbeg_reg, fbeg_next, fbeg_mid;
    off_t        fend_reg, fend_next, fend_mid;
    logic [3:0]  pfx_reg, pfx_next, pfx_mid;
    logic [15:0] pair_reg, pair_next, pair_mid;
    logic [1:0]  cnt_reg, cnt_next, cnt_mid;

    logic        b_valid, f_valid, go_name, name_end;
    token_item_t b_res, f_res, e_res;
    off_t        fb_name, after_lt;
    logic [7:0]  c;
    logic [15:0] pair_push;
    logic [1:0]  cnt_push;
    res_pair_t   res_raw;

    assign c         = item.data_byte;
    assign pair_push = {pair_reg[7:0], c};
    assign cnt_push  = (cnt_reg == 2'd2) ? 2'd2 : cnt_reg + 2'd1;
    assign name_end  = (c == CH_GT) || (c == CH_SPACE) || (c == CH_SLASH) ||
                       (c == CH_TAB) || (c == CH_LF);

    // Byte step
    always_comb
    begin
        mode_mid = mode_reg;
        pos_mid  = pos_reg;
        tok_mid  = tok_reg;
        fbeg_mid = fbeg_reg;
        fend_mid = fend_reg;
        pfx_mid  = pfx_reg;
        pair_mid = pair_reg;
        cnt_mid  = cnt_reg;
        b_valid  = 1'b0;
        b_res    = '0;
        go_name  = 1'b0;
        fb_name  = fbeg_reg;
        if (!item.end_only)
        begin
            pos_mid = inc_pos(pos_reg);
            case (mode_reg)
                M_TEXT:
                begin
                    if (c == CH_LT)
                    begin
                        b_valid  = 1'b1;
                        b_res    = mk(KIND_TEXT, tok_reg, fbeg_reg, sub0(pos_reg, fbeg_reg));
                        tok_mid  = pos_reg;
                        mode_mid = M_LT;
                    end
                end
                M_LT:
                begin
                    if (c == CH_BANG)
                        mode_mid = M_BANG;
                    else if (c == CH_QUEST)
                    begin
                        fbeg_mid = inc_pos(pos_reg);
                        mode_mid = M_DECL_NAME;
                    end
                    else if (c == CH_SLASH)
                    begin
                        fbeg_mid = inc_pos(pos_reg);
                        mode_mid = M_CLOSE_NAME;
                    end
                    else
                    begin
                        go_name = 1'b1;
                        fb_name = pos_reg;
                    end
                end
                M_BANG:
                begin
                    if (c == CH_DASH)
                        mode_mid = M_BANG_DASH;
                    else if (c == CH_LBRK)
                    begin
                        pfx_mid  = 4'd2;
                        mode_mid = M_CDATA_PFX;
                    end
                    else
                    begin
                        go_name = 1'b1;
                        fb_name = inc_pos(tok_reg);
                    end
                end
                M_BANG_DASH:
                begin
                    if (c == CH_DASH)
                    begin
                        fbeg_mid = inc_pos(pos_reg);
                        pair_mid = '0;
                        cnt_mid  = '0;
                        mode_mid = M_COMMENT;
                    end
                    else
                    begin
                        go_name = 1'b1;
                        fb_name = inc_pos(tok_reg);
                    end
                end
                M_CDATA_PFX:
                begin
                    if (!pfx_reg[3] && (c == cdata_char(pfx_reg[2:0])))
                    begin
                        pfx_mid = pfx_reg + 4'd1;
                        if (pfx_reg == 4'd7)
                        begin
                            fbeg_mid = inc_pos(pos_reg);
                            pair_mid = '0;
                            cnt_mid  = '0;
                            mode_mid = M_CDATA;
                        end
                    end
                    else
                    begin
                        go_name = 1'b1;
                        fb_name = inc_pos(tok_reg);
                    end
                end
                M_COMMENT, M_CDATA:
                begin
                    if ((c == CH_GT) && (cnt_reg == 2'd2) &&
                        (((mode_reg == M_COMMENT) && (pair_reg == {CH_DASH, CH_DASH})) ||
                         ((mode_reg == M_CDATA) && (pair_reg == {CH_RBRK, CH_RBRK}))))
                    begin
                        b_valid  = 1'b1;
                        b_res    = mk((mode_reg == M_COMMENT) ? KIND_COMMENT : KIND_CDATA,
                                      tok_reg, fbeg_reg, sub0(sub0(pos_reg, TWO), fbeg_reg));
                        mode_mid = M_SKIP;
                    end
                    else
                    begin
                        pair_mid = pair_push;
                        cnt_mid  = cnt_push;
                    end
                end
                M_DECL_NAME:
                begin
                    // terminator is never '>', so the body just records it
                    if ((c == CH_SPACE) || (c == CH_QUEST))
                    begin
                        fend_mid = pos_reg;
                        pair_mid = {8'h00, c};
                        cnt_mid  = 2'd1;
                        mode_mid = M_DECL_BODY;
                    end
                end
                M_DECL_BODY:
                begin
                    if ((c == CH_GT) && (cnt_reg != 2'd0) && (pair_reg[7:0] == CH_QUEST))
                    begin
                        b_valid  = 1'b1;
                        b_res    = mk(KIND_DECL, tok_reg, fbeg_reg, sub0(fend_reg, fbeg_reg));
                        mode_mid = M_SKIP;
                    end
                    else
                    begin
                        pair_mid = pair_push;
                        cnt_mid  = cnt_push;
                    end
                end
                M_CLOSE_NAME:
                begin
                    if (c == CH_GT)
                    begin
                        b_valid  = 1'b1;
                        b_res    = mk(KIND_CLOSE, tok_reg, fbeg_reg, sub0(pos_reg, fbeg_reg));
                        mode_mid = M_SKIP;
                    end
                    else if (c == CH_SPACE)
                    begin
                        fend_mid = pos_reg;
                        mode_mid = M_CLOSE_BODY;
                    end
                end
                M_CLOSE_BODY:
                begin
                    if (c == CH_GT)
                    begin
                        b_valid  = 1'b1;
                        b_res    = mk(KIND_CLOSE, tok_reg, fbeg_reg, sub0(fend_reg, fbeg_reg));
                        mode_mid = M_SKIP;
                    end
                end
                M_OPEN_NAME:
                    go_name = 1'b1;
                M_OPEN_BODY:
                begin
                    if (c == CH_GT)
                    begin
                        b_valid  = 1'b1;
                        b_res    = mk(((cnt_reg != 2'd0) && (pair_reg[7:0] == CH_SLASH)) ?
                                      KIND_SELFCLOSE : KIND_OPEN,
                                      tok_reg, fbeg_reg, sub0(fend_reg, fbeg_reg));
                        mode_mid = M_SKIP;
                    end
                    else
                    begin
                        pair_mid = pair_push;
                        cnt_mid  = cnt_push;
                    end
                end
                default:
                begin
                    if (!((c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR)))
                    begin
                        tok_mid = pos_reg;
                        if (c == CH_LT)
                            mode_mid = M_LT;
                        else
                        begin
                            fbeg_mid = pos_reg;
                            mode_mid = M_TEXT;
                        end
                    end
                end
            endcase

            // Tag name scan, shared by '<', by a broken '<!' prefix and by each further name byte
            if (go_name)
            begin
                fbeg_mid = fb_name;
                mode_mid = M_OPEN_NAME;
                if (name_end)
                begin
                    fend_mid = pos_reg;
                    if (c == CH_GT)
                    begin
                        b_valid  = 1'b1;
                        b_res    = mk(KIND_OPEN, tok_reg, fb_name, sub0(pos_reg, fb_name));
                        pair_mid = '0;
                        cnt_mid  = '0;
                        mode_mid = M_SKIP;
                    end
                    else
                    begin
                        pair_mid = {8'h00, c};
                        cnt_mid  = 2'd1;
                        mode_mid = M_OPEN_BODY;
                    end
                end
            end
        end
    end

    // End of document: pending token, then the end token
    assign after_lt = inc_pos(tok_mid);
    assign e_res    = mk(KIND_END, pos_mid, '0, '0);

    always_comb
    begin
        f_valid = 1'b1;
        case (mode_mid)
            M_TEXT:       f_res = mk(KIND_TEXT, tok_mid, fbeg_mid, sub0(pos_mid, fbeg_mid));
            M_LT:         f_res = mk(KIND_ERROR, tok_mid, tok_mid, off_t'(1));
            M_BANG, M_BANG_DASH, M_CDATA_PFX:
                          f_res = mk(KIND_OPEN, tok_mid, after_lt, sub0(pos_mid, after_lt));
            M_COMMENT:    f_res = mk(KIND_COMMENT, tok_mid, fbeg_mid,
                                     sub0(sub0(pos_mid, TWO), fbeg_mid));
            M_CDATA:      f_res = mk(KIND_CDATA, tok_mid, fbeg_mid,
                                     sub0(sub0(pos_mid, TWO), fbeg_mid));
            M_DECL_NAME:  f_res = mk(KIND_DECL, tok_mid, fbeg_mid, sub0(pos_mid, fbeg_mid));
            M_DECL_BODY:  f_res = mk(KIND_DECL, tok_mid, fbeg_mid, sub0(fend_mid, fbeg_mid));
            M_CLOSE_NAME: f_res = mk(KIND_CLOSE, tok_mid, fbeg_mid, sub0(pos_mid, fbeg_mid));
            M_CLOSE_BODY: f_res = mk(KIND_CLOSE, tok_mid, fbeg_mid, sub0(fend_mid, fbeg_mid));
            M_OPEN_NAME:  f_res = mk(KIND_OPEN, tok_mid, fbeg_mid, sub0(pos_mid, fbeg_mid));
            M_OPEN_BODY:  f_res = mk(KIND_OPEN, tok_mid, fbeg_mid, sub0(fend_mid, fbeg_mid));
            default:
            begin
                f_valid = 1'b0;
                f_res   = '0;
            end
        endcase
    end

    // Slot packing: at most two results, the third (end token) is dropped
    always_comb
    begin
        res_raw = '0;
        if (item.final_item)
        begin
            res_raw.r0_valid = 1'b1;
            res_raw.r1_valid = b_valid || f_valid;
            if (b_valid)
            begin
                res_raw.r0 = b_res;
                res_raw.r1 = f_valid ? f_res : e_res;
            end
            else if (f_valid)
            begin
                res_raw.r0 = f_res;
                res_raw.r1 = e_res;
            end
            else
                res_raw.r0 = e_res;
        end
        else
        begin
            res_raw.r0_valid = b_valid;
            res_raw.r0       = b_res;
        end
        res_raw.r0.run_last = !res_raw.r1_valid;
        res_raw.r1.run_last = 1'b1;
        res_raw.r0_valid    = res_raw.r0_valid && step;
        res_raw.r1_valid    = res_raw.r1_valid && step;
    end

    assign res = res_raw;

    // A final item returns everything to reset
    always_comb
    begin
        if (item.final_item)
        begin
            mode_next = M_SKIP;
            pos_next  = '0;
            tok_next  = '0;
            fbeg_next = '0;
            fend_next = '0;
            pfx_next  = '0;
            pair_next = '0;
            cnt_next  = '0;
        end
        else
        begin
            mode_next = mode_mid;
            pos_next  = pos_mid;
            tok_next  = tok_mid;
            fbeg_next = fbeg_mid;
            fend_next = fend_mid;
            pfx_next  = pfx_mid;
            pair_next = pair_mid;
            cnt_next  = cnt_mid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_SKIP;
            pos_reg  <= '0;
            tok_reg  <= '0;
            fbeg_reg <= '0;
            fend_reg <= '0;
            pfx_reg  <= '0;
            pair_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            tok_reg  <= tok_next;
            fbeg_reg <= fbeg_next;
            fend_reg <= fend_next;
            pfx_reg  <= pfx_next;
            pair_reg <= pair_next;
            cnt_reg  <= cnt_next;
        end
    end

    // A second result never comes without a first
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        res.r1_valid |-> res.r0_valid)
        else $error("second result without first");

    // A document always closes with run_last on its last result
    a_final_results: assert property (@(posedge clk) disable iff (!rst_n)
        (step && item.final_item) |->
            (res.r0_valid && (res.r1_valid ? res.r1.run_last : res.r0.run_last)))
        else $error("final item without closing result");

    // After a final item the scanner restarts at offset zero
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (step && item.final_item) |=> ((mode_reg == M_SKIP) && (pos_reg == '0)))
        else $error("state not cleared after final item");

endmodule

@@ rtl/core/xts_result_queue.sv @@
// xts_result_queue: small result FIFO, up to two writes and one read per cycle; out_stall holds the read.
// Depends on xts_pkg; drives the token channel of the top level.
module xts_result_queue
    import xts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  res_pair_t   wr,
    output logic        room,
    output logic        out_valid,
    input  logic        out_stall,
    output token_item_t out_item
);

    localparam int QW = $clog2(XTS_QUEUE_DEPTH);

    token_item_t mem_reg [XTS_QUEUE_DEPTH];
    logic [QW-1:0] head_reg, head_next, tail_reg, tail_next, tail_plus1;
    logic [QW:0]   count_reg, count_next, wr_n;
    logic          pop;

    assign tail_plus1 = tail_reg + QW'(1);
    assign wr_n       = (QW+1)'(wr.r0_valid) + (QW+1)'(wr.r1_valid);
    assign out_valid  = (count_reg != '0);
    assign out_item   = mem_reg[head_reg];
    assign pop        = out_valid && !out_stall;
    // room for a full pair of results
    assign room       = (count_reg <= (QW+1)'(XTS_QUEUE_DEPTH - 2));

    assign head_next  = pop ? head_reg + QW'(1) : head_reg;
    assign tail_next  = tail_reg + wr_n[QW-1:0];
    assign count_next = count_reg + wr_n - (QW+1)'(pop);

    always_ff @(posedge clk)
    begin
        if (wr.r0_valid)
            mem_reg[tail_reg] <= wr.r0;
        if (wr.r1_valid)
            mem_reg[tail_plus1] <= wr.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QW+1)'(XTS_QUEUE_DEPTH))
        else $error("result queue overflow");

    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_n != '0) |-> room)
        else $error("write without room");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (wr_n == '0)) |=> (count_reg == $past(count_reg) - (QW+1)'(1)))
        else $error("queue count lost a pop");

endmodule

@@ rtl/core/xml_token_scanner_core.sv @@
// xml_token_scanner_core: streaming XML tokenizer, top level.
// Depends on xts_pkg, xts_parse and xts_result_queue.
//
//   channel | direction | handshake                | item
//   --------+-----------+--------------------------+-------------------------------
//   byte    | in        | byte_valid / byte_stall  | byte_item_t  (one document byte)
//   token   | out       | token_valid / token_stall| token_item_t (one token report)
//
// Flow: one byte item per cycle while byte_stall is low; a byte waits in the input
// register until the queue has room, then the scanner step writes its zero, one or two
// tokens into a four-entry queue, and token_valid rises once they are registered there.
// The token port drains one token per cycle while token_stall is low; a step that
// yields two tokens (a final item) hands them out one after the other.
// Reset: rst_n clears scanner state, the input register's pending flag and the queue pointers at once.
// Stalls: byte_stall rises only while a byte waits and the queue has fewer than
// two free entries; token_stall holds the queue head in place.
module xml_token_scanner_core
    import xts_pkg::*;
#(
    parameter int OFFSET_BITS = XTS_OFFSET_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  byte_item_t  byte_item,
    output logic        token_valid,
    input  logic        token_stall,
    output token_item_t token_item
);

    logic       pend_reg, pend_next;
    byte_item_t item_reg;
    logic       accept, advance, room;
    res_pair_t  res;

    // Input register: holds one byte until the queue can take its results
    assign advance    = pend_reg && room;
    assign byte_stall = pend_reg && !room;
    assign accept     = byte_valid && !byte_stall;
    assign pend_next  = accept ? 1'b1 : (advance ? 1'b0 : pend_reg);

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= byte_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 1'b0;
        else
            pend_reg <= pend_next;
    end

    // Scanner step: state machine and offsets
    xts_parse #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_parse (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (item_reg),
        .res   (res)
    );

    // Result queue: splits a token pair onto the one-per-cycle token port
    xts_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (res),
        .room      (room),
        .out_valid (token_valid),
        .out_stall (token_stall),
        .out_item  (token_item)
    );

endmodule
